// File: hw/rtl/assert_macros.svh
// assertion macros used by the tone generator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/mwtg_pkg.sv
// shared types, codes and table functions for the tone generator
package mwtg_pkg;

  // waveform codes, unused codes fall back to sine
  typedef enum logic [2:0] {
    WAVE_SINE   = 3'd0,
    WAVE_SQUARE = 3'd1,
    WAVE_SAW    = 3'd2,
    WAVE_TRI    = 3'd3,
    WAVE_NOISE  = 3'd4
  } shape_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int STEP_W     = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SHAPE = 8'd1;

  // noise generator constants
  localparam logic [31:0] NOISE_SEED = 32'h9e37_79b9;
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  // pi/2 in q30
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // control bits carried with a word into the sine stage
  typedef struct packed {
    logic is_sine;
    logic negate;
  } s1_ctl_t;

  // one xorshift32 step
  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ (s << XS_A);
    b = a ^ (a >> XS_B);
    return b ^ (b << XS_C);
  endfunction

  // truncating quotient of non-negative values, only used while the table is built
  function automatic longint quot_u(input longint num, input longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  // quarter-wave sine entry k: taylor series in q30, rounded to fbits
  function automatic int sine_entry(input int k, input int tbits, input int fbits);
    longint x;
    longint x2;
    longint r;
    longint t;
    longint s;
    longint n;
    x  = (longint'(k) * HALF_PI_Q30) >>> tbits;
    x2 = (x * x) >>> 30;
    r  = longint'(1) << 30;
    for (n = 7; n >= 1; n--) begin
      t = (x2 * r) >>> 30;
      r = (longint'(1) << 30) - quot_u(t, (2 * n) * (2 * n + 1));
    end
    s = (x * r) >>> 30;
    if (s < 0) s = 0;
    s = (s + (longint'(1) << (29 - fbits))) >>> (30 - fbits);
    if (s > (longint'(1) << fbits) - 1) s = (longint'(1) << fbits) - 1;
    return int'(s);
  endfunction

endpackage

// File: hw/rtl/mwtg_sine_rom.sv
// quarter-wave sine rom with registered read
module mwtg_sine_rom #(
  parameter int TABLE_BITS = 10,
  parameter int FRAC_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [TABLE_BITS:0]   rd_addr,
  output logic [FRAC_BITS-1:0]  rd_data
);
  import mwtg_pkg::*;

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  typedef logic [FRAC_BITS-1:0] rom_arr_t [DEPTH];

  // table contents built at elaboration
  function automatic rom_arr_t build_rom();
    rom_arr_t tbl;
    for (int k = 0; k < DEPTH; k++) begin
      tbl[k] = FRAC_BITS'(sine_entry(k, TABLE_BITS, FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [FRAC_BITS-1:0] rd_data_r;

  // registered read, held while the stage stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/mwtg_osc.sv
// phase accumulator, noise register and per-shape sample logic
module mwtg_osc #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          s1_load,
  input  logic                          restart,
  input  logic [mwtg_pkg::STEP_W-1:0]   phase_step,
  input  mwtg_pkg::shape_t              wave_shape,
  output logic [SINE_TABLE_BITS:0]      rom_addr,
  output logic signed [SAMPLE_BITS-1:0] s1_pre,
  output mwtg_pkg::s1_ctl_t             s1_ctl
);
  import mwtg_pkg::*;

  localparam int F    = SAMPLE_BITS - 1;
  localparam int TW   = SINE_TABLE_BITS + 2;
  localparam int MAXB = (F + 2 > TW) ? F + 2 : TW;
  localparam int PAD  = (MAXB > PHASE_BITS) ? MAXB - PHASE_BITS : 0;
  localparam int EW   = PHASE_BITS + PAD + 1;
  localparam int AW   = SINE_TABLE_BITS + 1;

  localparam logic [F+1:0]         TWO_ONE = (F + 2)'(1) << (F + 1);
  localparam logic signed [F+2:0]  ONE_W   = (F + 3)'(1) << F;
  localparam logic signed [F:0]    MAXV    = {1'b0, {F{1'b1}}};
  localparam logic [AW-1:0]        TBL_N   = AW'(1) << SINE_TABLE_BITS;

  logic [PHASE_BITS-1:0]        phase_r;
  logic [PHASE_BITS-1:0]        phase_nxt;
  logic [31:0]                  noise_r;
  logic [31:0]                  noise_nxt;
  logic signed [F:0]            s1_pre_r;
  logic signed [F:0]            s1_pre_nxt;
  s1_ctl_t                      s1_ctl_r;
  s1_ctl_t                      s1_ctl_nxt;

  logic [PHASE_BITS-1:0]        phase_base;
  logic [EW-1:0]                phase_ext;
  logic [PHASE_BITS+23:0]       step_wide;
  logic [PHASE_BITS-1:0]        step_s;
  logic [F:0]                   saw_u;
  logic [F+1:0]                 tri_q;
  logic [F+1:0]                 tri_d;
  logic signed [F+2:0]          tri_v;
  logic signed [F:0]            tri_s;
  logic [TW-1:0]                sin_f;
  logic [SINE_TABLE_BITS-1:0]   sin_i;
  logic [31:0]                  noise_base;
  logic [31:0]                  noise_adv;

  // restart clears phase and reseeds noise before sampling
  assign phase_base = restart ? '0 : phase_r;
  assign noise_base = restart ? NOISE_SEED : noise_r;
  assign noise_adv  = xorshift32(noise_base);

  // phase fraction padded so any needed top-bit slice exists
  assign phase_ext = {phase_base, {(PAD + 1){1'b0}}};
  assign saw_u     = phase_ext[EW-1 -: F + 1];
  assign tri_q     = phase_ext[EW-1 -: F + 2];
  assign sin_f     = phase_ext[EW-1 -: TW];

  // step rescaled from 0.24 to the accumulator width
  assign step_wide = {phase_step, {PHASE_BITS{1'b0}}};
  assign step_s    = step_wide[PHASE_BITS+23:24];

  // triangle: one minus distance from half phase, top code saturated
  always_comb begin
    if (tri_q[F+1]) begin
      tri_d = {1'b0, tri_q[F:0]};
    end else begin
      tri_d = TWO_ONE - {1'b0, tri_q[F:0]};
    end
    tri_v = ONE_W - signed'({1'b0, tri_d});
    if (tri_v == ONE_W) begin
      tri_s = MAXV;
    end else begin
      tri_s = tri_v[F:0];
    end
  end

  // sine address: mirror in odd quadrants
  assign sin_i    = sin_f[SINE_TABLE_BITS-1:0];
  assign rom_addr = sin_f[TW-2] ? (TBL_N - {1'b0, sin_i}) : {1'b0, sin_i};

  // shape select and state update
  always_comb begin
    s1_ctl_nxt.is_sine = 1'b0;
    s1_ctl_nxt.negate  = sin_f[TW-1];
    noise_nxt          = noise_base;
    phase_nxt          = phase_base + step_s;
    case (wave_shape)
      WAVE_SQUARE: begin
        s1_pre_nxt = {phase_base[PHASE_BITS-1], {F{~phase_base[PHASE_BITS-1]}}};
      end
      WAVE_SAW: begin
        s1_pre_nxt = {~saw_u[F], saw_u[F-1:0]};
      end
      WAVE_TRI: begin
        s1_pre_nxt = tri_s;
      end
      WAVE_NOISE: begin
        noise_nxt  = noise_adv;
        s1_pre_nxt = {~noise_adv[31], noise_adv[30 -: F]};
      end
      default: begin
        s1_ctl_nxt.is_sine = 1'b1;
        s1_pre_nxt         = '0;
      end
    endcase
  end

  // oscillator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      noise_r <= NOISE_SEED;
    end else if (accept) begin
      phase_r <= phase_nxt;
      noise_r <= noise_nxt;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pre_r <= s1_pre_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  assign s1_pre = s1_pre_r;
  assign s1_ctl = s1_ctl_r;

endmodule

// File: hw/rtl/multi_waveform_tone_generator.sv
// top level of the multi-waveform tone generator
// Tone generator: each accepted word on the in_ channel yields exactly one
// signed Q1.(SAMPLE_BITS-1) sample on the out_ channel, in order. Sine, square,
// saw, triangle or xorshift32 noise is chosen by wave_shape (register 1), and
// the phase advances by phase_step (register 0, unsigned 0.24 of a cycle) after
// each sample. in_restart clears the phase and reseeds the noise before the
// sample. Throughput is one word per clock while out_ready keeps the output
// moving; a word passes through stage one, loaded together with the registered
// read of the quarter-wave sine rom on the accepting edge, and then the output
// register, from which its sample is offered on out_. Configuration writes are
// taken at once and should only be issued while no samples are in flight.
`include "assert_macros.svh"

module multi_waveform_tone_generator #(
  parameter int PHASE_BITS      = 24,
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mwtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mwtg_pkg::STEP_W-1:0]       cfg_data
);
  import mwtg_pkg::*;

  localparam int F = SAMPLE_BITS - 1;
  localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {F{1'b1}}};

  logic [STEP_W-1:0]              phase_step_r;
  shape_t                         wave_shape_r;
  logic                           s1_valid_r;
  logic                           s1_valid_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_nxt;

  logic                           accept;
  logic                           s1_adv;
  logic                           out_adv;
  logic [SINE_TABLE_BITS:0]       rom_addr;
  logic [F-1:0]                   rom_data;
  logic signed [SAMPLE_BITS-1:0]  s1_pre;
  s1_ctl_t                        s1_ctl;
  logic signed [SAMPLE_BITS-1:0]  sine_pos;
  logic                           restart_sq;

  // configuration registers, unknown indexes ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      wave_shape_r <= WAVE_SINE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_data;
        CFG_WAVE_SHAPE: wave_shape_r <= shape_t'(cfg_data[2:0]);
        default: ;
      endcase
    end
  end

  // pipeline flow control: each stage moves when the one after has room
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;
  assign accept   = in_valid && in_ready;

  // oscillator and stage one
  mwtg_osc #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_osc (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .s1_load    (s1_adv),
    .restart    (in_restart),
    .phase_step (phase_step_r),
    .wave_shape (wave_shape_r),
    .rom_addr   (rom_addr),
    .s1_pre     (s1_pre),
    .s1_ctl     (s1_ctl)
  );

  // quarter-wave table, read alongside stage one
  mwtg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS),
    .FRAC_BITS  (F)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (s1_adv),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // final sample select with sign for the lower half-cycle
  assign sine_pos = {1'b0, rom_data};

  always_comb begin
    if (s1_ctl.is_sine) begin
      out_sample_nxt = s1_ctl.negate ? (SAMPLE_BITS'(0) - sine_pos) : sine_pos;
    end else begin
      out_sample_nxt = s1_pre;
    end
    s1_valid_nxt  = s1_adv ? accept : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // restarted square word starts at the top code
  assign restart_sq = accept && in_restart && (wave_shape_r == WAVE_SQUARE);

  // checks
  `ASSERT_NEXT(a_restart_square, clk, rst_n, restart_sq, s1_valid_r && s1_pre == MAXV)
  `ASSERT_NEXT(a_stage_held, clk, rst_n, s1_valid_r && !out_adv, s1_valid_r)
  `ASSERT_SAME(a_no_overrun, clk, rst_n, accept, !(s1_valid_r && out_valid_r && !out_ready))

endmodule
